@@ rtl/core/rmf3_pkg.sv @@
// Shared constants, types and compare functions for the RGB 3x3 median filter.
package rmf3_pkg;

   localparam int MAX_LINE_WIDTH_DEFAULT = 1024;

   localparam int PIX_W        = 8;
   localparam int NUM_CHAN     = 3;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 12;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd64;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd64;

   // Smallest usable frame dimension; the filter needs three columns and three lines.
   localparam int DIM_MIN = 3;

   typedef logic [PIX_W-1:0] chan_type;

   // One window column of one channel, sorted.
   typedef struct packed {
      chan_type hi;
      chan_type mid;
      chan_type lo;
   } triple_type;

   function automatic chan_type min2(input chan_type a, input chan_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic chan_type max2(input chan_type a, input chan_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic triple_type sort3(input chan_type a, input chan_type b,
                                        input chan_type c);
      chan_type   x;
      chan_type   y;
      chan_type   t;
      triple_type s;
      x     = min2(a, b);
      y     = max2(a, b);
      s.lo  = min2(x, c);
      t     = max2(x, c);
      s.mid = min2(y, t);
      s.hi  = max2(y, t);
      return s;
   endfunction

   function automatic chan_type min3(input chan_type a, input chan_type b,
                                     input chan_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic chan_type max3(input chan_type a, input chan_type b,
                                     input chan_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic chan_type med3(input chan_type a, input chan_type b,
                                     input chan_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage

@@ rtl/core/rgb_median_filter_3x3.sv @@
// Top level of the streaming RGB 3x3 median filter.
//
// Pixels enter on the req_ channel in raster order, one transfer per clock at most.
// Each pixel that completes a window centered on an interior pixel yields one
// result on the rsp_ channel: the per-channel median of the nine window pixels.
// Border pixels yield nothing. rsp_frame_end marks the last result of a frame.
// Frame geometry is set through the csr_ port (index 0 width, index 1 height),
// which is always ready; write it only while no pixel is in flight.
// The pixel that completes a window passes stage 1 and stage 2, then its result
// is held in the result register. Throughput is one pixel per clock unless stalled,
// set by the two line memories, each read and written once per pixel.
// A receiver stall holds the result register; the two internal stages keep
// taking pixels until both are full, and only then is req_stall raised.
// Reset clears the pipeline, the column and line counters and restores a 64x64
// geometry. Line memory contents are not cleared; the first two lines of a
// frame never reach a result, so no clearing pass is needed.
module rgb_median_filter_3x3 #(
   parameter int MAX_LINE_WIDTH = rmf3_pkg::MAX_LINE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rmf3_pkg::PIX_W-1:0]        req_pixel_red,
   input  logic [rmf3_pkg::PIX_W-1:0]        req_pixel_green,
   input  logic [rmf3_pkg::PIX_W-1:0]        req_pixel_blue,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rmf3_pkg::PIX_W-1:0]        rsp_median_red,
   output logic [rmf3_pkg::PIX_W-1:0]        rsp_median_green,
   output logic [rmf3_pkg::PIX_W-1:0]        rsp_median_blue,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rmf3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rmf3_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int COL_W = $clog2(MAX_LINE_WIDTH);
   localparam int PIX_W = rmf3_pkg::PIX_W;
   localparam int NCH   = rmf3_pkg::NUM_CHAN;
   localparam int ROW_W = rmf3_pkg::HEIGHT_REG_W;
   localparam int WREG  = rmf3_pkg::WIDTH_REG_W;
   localparam int LINE_W = NCH * PIX_W;

   localparam logic [COL_W-1:0] COL_FIRST_INNER = COL_W'(2);
   localparam logic [ROW_W-1:0] ROW_FIRST_INNER = ROW_W'(2);
   localparam logic [ROW_W-1:0] DIM_MIN_R       = ROW_W'(rmf3_pkg::DIM_MIN);
   localparam logic [ROW_W-1:0] MAX_LAST_COL    = ROW_W'(MAX_LINE_WIDTH - 1);

   // Configuration registers.
   logic [WREG-1:0]  width_ff;
   logic [ROW_W-1:0] height_ff;

   // Position counters of the next incoming pixel.
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   // Line memories: line1 holds the previous line, line2 the one before it.
   logic [LINE_W-1:0] line1_mem [MAX_LINE_WIDTH];
   logic [LINE_W-1:0] line2_mem [MAX_LINE_WIDTH];

   // Stage 1: pixel plus the two pixels above it read from the line memories.
   logic              v1_ff;
   logic [LINE_W-1:0] pix1_ff;
   logic [LINE_W-1:0] up1_ff;
   logic [LINE_W-1:0] up2_ff;
   logic [COL_W-1:0]  col1_ff;
   logic              emit1_ff;
   logic              fe1_ff;

   // Stage 2: window of three sorted columns per channel.
   logic                 v2_ff;
   logic                 emit2_ff;
   logic                 fe2_ff;
   rmf3_pkg::triple_type win_ff [3][NCH];

   // Result register.
   logic                  rsp_valid_ff;
   rmf3_pkg::chan_type    med_ff [NCH];
   logic                  frame_end_ff;

   logic [ROW_W-1:0]  width_last;
   logic [ROW_W-1:0]  last_col_wide;
   logic [COL_W-1:0]  last_col;
   logic [ROW_W-1:0]  last_row;
   logic              req_accept;
   logic              out_ready;
   logic              s2_ready;
   logic              s1_ready;
   logic              s1_advance;
   logic              emit_in;
   logic              fe_in;
   logic [LINE_W-1:0] pix_in;
   rmf3_pkg::triple_type col_sorted [NCH];
   rmf3_pkg::chan_type   med_in [NCH];

   // Effective last column and last line after clamping the programmed geometry.
   always_comb begin
      width_last = (ROW_W'(width_ff) < DIM_MIN_R) ? (DIM_MIN_R - ROW_W'(1))
                                                  : (ROW_W'(width_ff) - ROW_W'(1));
      last_col_wide = (width_last > MAX_LAST_COL) ? MAX_LAST_COL : width_last;
      last_col = last_col_wide[COL_W-1:0];
      last_row = (height_ff < DIM_MIN_R) ? (DIM_MIN_R - ROW_W'(1))
                                         : (height_ff - ROW_W'(1));
   end

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !v2_ff || out_ready;
   assign s1_ready   = !v1_ff || s2_ready;
   assign s1_advance = v1_ff && s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && s1_ready;
   assign csr_ready  = 1'b1;

   assign pix_in  = {req_pixel_red, req_pixel_green, req_pixel_blue};
   assign emit_in = (col_ff >= COL_FIRST_INNER) && (row_ff >= ROW_FIRST_INNER) &&
                    (col_ff <= last_col) && (row_ff <= last_row);
   assign fe_in   = (col_ff == last_col) && (row_ff == last_row);

   // Sort the new window column (two lines up, one line up, current) per channel.
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         col_sorted[c] = rmf3_pkg::sort3(up2_ff[LINE_W-1-c*PIX_W -: PIX_W],
                                         up1_ff[LINE_W-1-c*PIX_W -: PIX_W],
                                         pix1_ff[LINE_W-1-c*PIX_W -: PIX_W]);
      end
   end

   // Median of nine from three sorted columns: the median of the largest low,
   // the middle of the mids and the smallest high.
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         med_in[c] = rmf3_pkg::med3(
            rmf3_pkg::max3(win_ff[0][c].lo, win_ff[1][c].lo, win_ff[2][c].lo),
            rmf3_pkg::med3(win_ff[0][c].mid, win_ff[1][c].mid, win_ff[2][c].mid),
            rmf3_pkg::min3(win_ff[0][c].hi, win_ff[1][c].hi, win_ff[2][c].hi));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rmf3_pkg::WIDTH_RESET;
         height_ff <= rmf3_pkg::HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rmf3_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[WREG-1:0];
            end
            rmf3_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         if (col_ff >= last_col) begin
            col_ff <= '0;
            row_ff <= (row_ff >= last_row) ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Line memories: read on transfer, written when the pixel leaves stage 1.
   // A column is revisited no sooner than three pixels later, so the write
   // always lands before the next read of the same column.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         up1_ff <= line1_mem[col_ff];
         up2_ff <= line2_mem[col_ff];
      end
      if (s1_advance) begin
         line1_mem[col1_ff] <= pix1_ff;
         line2_mem[col1_ff] <= up1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (s1_ready) begin
         v1_ff <= req_valid;
      end
      if (req_accept) begin
         pix1_ff  <= pix_in;
         col1_ff  <= col_ff;
         emit1_ff <= emit_in;
         fe1_ff   <= fe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (s2_ready) begin
         v2_ff <= v1_ff;
      end
      if (s1_advance) begin
         emit2_ff <= emit1_ff;
         fe2_ff   <= fe1_ff;
         for (int c = 0; c < NCH; c++) begin
            win_ff[0][c] <= win_ff[1][c];
            win_ff[1][c] <= win_ff[2][c];
            win_ff[2][c] <= col_sorted[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= v2_ff && emit2_ff;
      end
      if (out_ready && v2_ff && emit2_ff) begin
         frame_end_ff <= fe2_ff;
         for (int c = 0; c < NCH; c++) begin
            med_ff[c] <= med_in[c];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_red   = med_ff[0];
   assign rsp_median_green = med_ff[1];
   assign rsp_median_blue  = med_ff[2];
   assign rsp_frame_end    = frame_end_ff;

endmodule

@@ rtl/core/rmf3_checker.sv @@
// Port-level checks for the RGB 3x3 median filter, bound to the top level.
module rmf3_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [rmf3_pkg::PIX_W-1:0]        rsp_median_red,
   input logic [rmf3_pkg::PIX_W-1:0]        rsp_median_green,
   input logic [rmf3_pkg::PIX_W-1:0]        rsp_median_blue,
   input logic                              rsp_frame_end
);

   // The result channel is empty in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // Backpressure on the input only comes from a stalled, pending result.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result does not change.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_median_red) &&
         $stable(rsp_median_green) && $stable(rsp_median_blue) &&
         $stable(rsp_frame_end)))
      else $error("result changed while stalled");

endmodule

bind rgb_median_filter_3x3 rmf3_checker u_rmf3_checker (.*);
